### src/gwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants of the glob wildcard matcher: command codes,
// wildcard bytes, the broadcast control word and the link between cells.
// ----------------------------------------------------------------------------
package gwm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_FINISH  = 2'd3
  } cmd_t;

  localparam logic [7:0] STAR_BYTE     = 8'h2A;
  localparam logic [7:0] QUESTION_BYTE = 8'h3F;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [7:0] data;
    logic       clear;
    logic       store;
    logic       load;
    logic       adv;
    logic       use_act;
  } ctrl_t;

  // handed from one cell to the next
  typedef struct packed {
    logic fwd;
    logic carry;
    logic grow;
  } link_t;

endpackage

### src/gwm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm channel interfaces
// Valid/ready channels of the matcher: the command stream and the result
// stream. A transaction completes when valid and ready are both high.
// ----------------------------------------------------------------------------
interface gwm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface gwm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic status;

  modport source (output valid, output matched, output status, input ready);
  modport sink   (input valid, input matched, input status, output ready);
endinterface

### src/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Whole-string glob matcher with '*' and '?' over a row of pattern cells.
// ----------------------------------------------------------------------------
// A new transaction may follow in the next cycle; a finish writes its result
// into the output register as it is accepted, and commands keep flowing
// while that result waits, unless a further result would overwrite it. The
// clock period is set by the ripple of star closure through the row of
// PATTERN_MAX+1 cells. There is no clearing pass after reset; the pattern
// store needs only its length.
module glob_wildcard_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input logic clk,
  input logic rst,
  gwm_cmd_if.sink   cmd_ch,
  gwm_res_if.source res_ch
);
  import gwm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic [LW-1:0] len;
  logic          pattern_ended;
  logic          overflow;
  logic          subject_open;
  logic          subject_ended;
  logic          res_valid;
  logic          res_matched;
  logic          res_status;

  ctrl_t               ctrl;
  link_t               links [0:PATTERN_MAX+1];
  logic [PATTERN_MAX:0] e_vec;

  cmd_t cmd;
  logic acc;
  logic byte_zero;
  logic room;
  logic hit;

  assign cmd       = cmd_t'(cmd_ch.command);
  assign cmd_ch.ready = !res_valid || res_ch.ready || (cmd != CMD_FINISH);
  assign acc       = cmd_ch.valid && cmd_ch.ready;
  assign byte_zero = (cmd_ch.data_byte == 8'd0);
  assign room      = len < LW'(PATTERN_MAX);
  assign hit       = e_vec[len];

  always_comb begin
    ctrl.data    = cmd_ch.data_byte;
    ctrl.clear   = acc && (cmd == CMD_CLEAR);
    ctrl.store   = acc && (cmd == CMD_APPEND) && !pattern_ended && !byte_zero && room;
    ctrl.load    = acc && (cmd == CMD_SUBJECT);
    ctrl.adv     = !(subject_open && subject_ended) && !byte_zero;
    ctrl.use_act = subject_open;
  end

  assign links[0] = '0;

  for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_cell
    gwm_cell #(
      .IDX (i),
      .LW  (LW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .len      (len),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .e_out    (e_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len           <= '0;
      pattern_ended <= 1'b0;
      overflow      <= 1'b0;
      subject_open  <= 1'b0;
      subject_ended <= 1'b0;
    end else if (acc) begin
      case (cmd)
        CMD_CLEAR: begin
          len           <= '0;
          pattern_ended <= 1'b0;
          overflow      <= 1'b0;
          subject_open  <= 1'b0;
          subject_ended <= 1'b0;
        end
        CMD_APPEND: begin
          subject_open  <= 1'b0;
          subject_ended <= 1'b0;
          if (!pattern_ended) begin
            if (byte_zero) begin
              pattern_ended <= 1'b1;
            end else if (room) begin
              len <= len + LW'(1);
            end else begin
              overflow <= 1'b1;
            end
          end
        end
        CMD_SUBJECT: begin
          subject_open  <= 1'b1;
          subject_ended <= (subject_open && subject_ended) || byte_zero;
        end
        CMD_FINISH: begin
          subject_open  <= 1'b0;
          subject_ended <= 1'b0;
        end
        default: begin
          subject_open <= subject_open;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc && (cmd == CMD_FINISH)) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (cmd == CMD_FINISH)) begin
      res_matched <= hit && !overflow;
      res_status  <= overflow;
    end
  end

  assign res_ch.valid   = res_valid;
  assign res_ch.matched = res_matched;
  assign res_ch.status  = res_status;

  a_tail_quiet: assert property (@(posedge clk) disable iff (rst)
    links[PATTERN_MAX+1] == '0)
    else $error("activity passed beyond the last pattern position");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(PATTERN_MAX))
    else $error("pattern length beyond store");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    (acc && (cmd == CMD_FINISH)) |=> res_ch.valid)
    else $error("finish transaction gave no result");

  a_overflow_no_match: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid |-> !(res_ch.matched && res_ch.status))
    else $error("match reported with overflowed pattern");

  a_clear_effect: assert property (@(posedge clk) disable iff (rst)
    (acc && (cmd == CMD_CLEAR)) |=> (len == '0) && !overflow && !subject_open)
    else $error("clear left pattern state behind");

endmodule

### src/gwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: holds its pattern byte, its bit of the start set and
// its bit of the active set, and passes match, star and start-set growth on
// to the next position.
// ----------------------------------------------------------------------------
module gwm_cell #(
  parameter int IDX = 0,
  parameter int LW  = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  gwm_pkg::ctrl_t ctrl,
  input  logic [LW-1:0] len,
  input  gwm_pkg::link_t link_in,
  output gwm_pkg::link_t link_out,
  output logic          e_out
);
  import gwm_pkg::*;

  logic [7:0] pat;
  logic       init_bit;
  logic       act_bit;

  logic en;
  logic star;
  logic e;
  logic n;
  logic wr_here;

  assign en      = LW'(IDX) < len;
  assign star    = en && (pat == STAR_BYTE);
  assign e       = ctrl.use_act ? act_bit : init_bit;
  assign n       = (e && star) || link_in.fwd || link_in.carry;
  assign wr_here = ctrl.store && (len == LW'(IDX));
  assign e_out   = e;

  assign link_out.fwd   = e && en && !star &&
                          ((pat == QUESTION_BYTE) || (pat == ctrl.data));
  assign link_out.carry = n && star;
  assign link_out.grow  = wr_here && init_bit && (ctrl.data == STAR_BYTE);

  always_ff @(posedge clk) begin
    if (wr_here) begin
      pat <= ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_bit <= (IDX == 0);
      act_bit  <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        init_bit <= (IDX == 0);
      end else if (ctrl.store && link_in.grow) begin
        init_bit <= 1'b1;
      end
      if (ctrl.load) begin
        act_bit <= ctrl.adv ? n : e;
      end
    end
  end

endmodule

### test/tb_glob_wildcard_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glob_wildcard_matcher
// Sends clear, pattern, subject and finish transactions into the matcher and
// checks every finish result against a local model. The model keeps the
// pattern bytes and the set of live pattern positions. Both channels stall
// at random. A directed opening covers the corner cases. Random pattern and
// subject sequences follow, including ones that run past the pattern store.
// ----------------------------------------------------------------------------
module tb_glob_wildcard_matcher;
  import gwm_pkg::*;

  localparam int PMAX         = 32;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
    bit         hold;
  } cmd_item_t;

  typedef struct {
    logic matched;
    logic status;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gwm_cmd_if cmd_ch ();
  gwm_res_if res_ch ();

  glob_wildcard_matcher #(.PATTERN_MAX(PMAX)) uut (
    .clk   (clk),
    .rst   (rst),
    .cmd_ch(cmd_ch),
    .res_ch(res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cmd_item_t   cmd_items [$];
  match_t      pending_matches [$];
  int unsigned total_items;
  int unsigned sent_count    = 0;
  int unsigned finishes_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count   = 0;
  int          phase         = 0;
  int          send_idle_pct [3] = '{23, 82, 0};
  int          recv_idle_pct [3] = '{82, 23, 0};

  // model state
  logic [7:0]  pat_bytes [PMAX];
  int unsigned pat_len      = 0;
  logic [PMAX:0] live_pos   = '0;
  bit          subj_open    = 1'b0;
  bit          pat_done     = 1'b0;
  bit          subj_done    = 1'b0;
  bit          pat_overflow = 1'b0;

  function automatic logic [PMAX:0] star_spread(logic [PMAX:0] s);
    for (int i = 0; i < pat_len; i++) begin
      if (s[i] && pat_bytes[i] == STAR_BYTE) s[i + 1] = 1'b1;
    end
    return s;
  endfunction

  task automatic open_subject();
    live_pos  = star_spread({{PMAX{1'b0}}, 1'b1});
    subj_open = 1'b1;
    subj_done = 1'b0;
  endtask

  task automatic glob_predict(input cmd_t cmd, input logic [7:0] data);
    match_t        res;
    logic [PMAX:0] nxt;
    case (cmd)
      CMD_CLEAR: begin
        pat_len      = 0;
        pat_done     = 1'b0;
        pat_overflow = 1'b0;
        subj_open    = 1'b0;
        subj_done    = 1'b0;
        live_pos     = '0;
      end
      CMD_APPEND: begin
        subj_open = 1'b0;
        subj_done = 1'b0;
        live_pos  = '0;
        if (!pat_done) begin
          if (data == 8'h00) begin
            pat_done = 1'b1;
          end else if (pat_len < PMAX) begin
            pat_bytes[pat_len] = data;
            pat_len++;
          end else begin
            pat_overflow = 1'b1;
          end
        end
      end
      CMD_SUBJECT: begin
        if (!subj_open) open_subject();
        if (!subj_done) begin
          if (data == 8'h00) begin
            subj_done = 1'b1;
          end else begin
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
              if (live_pos[i]) begin
                if (pat_bytes[i] == STAR_BYTE) nxt[i] = 1'b1;
                else if (pat_bytes[i] == QUESTION_BYTE || pat_bytes[i] == data)
                  nxt[i + 1] = 1'b1;
              end
            end
            live_pos = star_spread(nxt);
          end
        end
      end
      default: begin
        if (!subj_open) open_subject();
        res.matched = live_pos[pat_len] && !pat_overflow;
        res.status  = pat_overflow;
        pending_matches.push_back(res);
        subj_open = 1'b0;
        subj_done = 1'b0;
        live_pos  = '0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  task automatic push_cmd(input cmd_t cmd, input logic [7:0] data, input bit hold = 1'b0);
    cmd_item_t it;
    it.cmd  = cmd;
    it.data = data;
    it.hold = hold;
    cmd_items.push_back(it);
  endtask

  function automatic logic [7:0] subject_byte();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 1) ? 8'h61 : 8'h62;
    return 8'($urandom_range(1, 255));
  endfunction

  // command driver
  always @(posedge clk) begin
    bit        nxt_valid;
    cmd_item_t it;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      nxt_valid = cmd_ch.valid;
      if (cmd_ch.valid && cmd_ch.ready) begin
        glob_predict(cmd_t'(cmd_ch.command), cmd_ch.data_byte);
        if (cmd_t'(cmd_ch.command) == CMD_FINISH) finishes_sent++;
        sent_count++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && cmd_items.size() > 0 &&
          !(cmd_items[0].hold && finishes_sent != results_seen) &&
          $urandom_range(0, 99) >= send_idle_pct[phase]) begin
        it = cmd_items.pop_front();
        cmd_ch.command   <= it.cmd;
        cmd_ch.data_byte <= it.data;
        nxt_valid = 1'b1;
      end
      cmd_ch.valid <= nxt_valid;
      phase <= (sent_count * 3 < total_items) ? 0 :
               (sent_count * 3 < total_items * 2) ? 1 : 2;
    end
  end

  // result monitor
  always @(posedge clk) begin
    match_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (pending_matches.size() == 0) begin
          report_mismatch("result transaction with no finish pending");
        end else begin
          want = pending_matches.pop_front();
          if (res_ch.matched !== want.matched)
            report_mismatch($sformatf("matched %b, expected %b", res_ch.matched,
                                      want.matched));
          if (res_ch.status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", res_ch.status,
                                      want.status));
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct[phase]);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("glob_wildcard_matcher test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  pat [$];
    logic [7:0]  subj [$];
    int unsigned plen;
    int unsigned r;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CMD_CLEAR;
    cmd_ch.data_byte = 8'h00;
    res_ch.ready     = 1'b0;

    // empty pattern against empty and one-byte subjects
    push_cmd(CMD_FINISH, 8'hFF);
    push_cmd(CMD_SUBJECT, 8'hFF);
    push_cmd(CMD_FINISH, 8'h00);
    // pattern "*?" plus a high byte, terminated, then an ignored append
    push_cmd(CMD_CLEAR, 8'hFF);
    push_cmd(CMD_APPEND, STAR_BYTE);
    push_cmd(CMD_APPEND, QUESTION_BYTE);
    push_cmd(CMD_APPEND, 8'h80);
    push_cmd(CMD_APPEND, 8'h00);
    push_cmd(CMD_APPEND, 8'h78);
    // subject ended by a zero byte, trailing byte ignored
    push_cmd(CMD_SUBJECT, 8'h71);
    push_cmd(CMD_SUBJECT, 8'h80);
    push_cmd(CMD_SUBJECT, 8'h00);
    push_cmd(CMD_SUBJECT, 8'h7F);
    push_cmd(CMD_FINISH, 8'h55);
    push_cmd(CMD_FINISH, 8'hAA);
    // append abandons an open subject
    push_cmd(CMD_SUBJECT, 8'h01);
    push_cmd(CMD_APPEND, 8'h55);
    push_cmd(CMD_SUBJECT, 8'h80);
    push_cmd(CMD_FINISH, 8'h00);
    // lone star matches the empty subject and wildcard bytes as literals
    push_cmd(CMD_CLEAR, 8'h00);
    push_cmd(CMD_APPEND, STAR_BYTE);
    push_cmd(CMD_FINISH, 8'h00);
    push_cmd(CMD_SUBJECT, STAR_BYTE);
    push_cmd(CMD_SUBJECT, QUESTION_BYTE);
    push_cmd(CMD_FINISH, 8'h00);

    // hold until the directed results are all in
    push_cmd(CMD_CLEAR, 8'h00, 1'b1);
    while (cmd_items.size() < RANDOM_ITEMS + 26) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          push_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        plen = (r < 70) ? $urandom_range(0, 6) :
               (r < 90) ? $urandom_range(7, 31) : $urandom_range(32, 34);
        pat.delete();
        push_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        repeat (plen) begin
          r = $urandom_range(0, 99);
          if (r < 30) pat.push_back(STAR_BYTE);
          else if (r < 45) pat.push_back(QUESTION_BYTE);
          else if (r < 90) pat.push_back(r[0] ? 8'h61 : 8'h62);
          else pat.push_back(8'($urandom_range(1, 255)));
          push_cmd(CMD_APPEND, pat[$]);
        end
        if ($urandom_range(0, 99) < 70) begin
          push_cmd(CMD_APPEND, 8'h00);
          if ($urandom_range(0, 3) == 0) push_cmd(CMD_APPEND, 8'($urandom_range(1, 255)));
        end
        repeat ($urandom_range(1, 5)) begin
          subj.delete();
          foreach (pat[i]) begin
            if (pat[i] == STAR_BYTE) repeat ($urandom_range(0, 3)) subj.push_back(subject_byte());
            else if (pat[i] == QUESTION_BYTE) subj.push_back(subject_byte());
            else subj.push_back(pat[i]);
          end
          r = $urandom_range(0, 99);
          if (r < 15 && subj.size() > 0)
            subj[$urandom_range(0, subj.size() - 1)] = subject_byte();
          else if (r < 25 && subj.size() > 0)
            subj.delete($urandom_range(0, subj.size() - 1));
          else if (r < 35)
            subj.insert($urandom_range(0, subj.size()), subject_byte());
          foreach (subj[i]) push_cmd(CMD_SUBJECT, subj[i]);
          if ($urandom_range(0, 9) == 0) begin
            push_cmd(CMD_SUBJECT, 8'h00);
            push_cmd(CMD_SUBJECT, subject_byte());
          end
          push_cmd(CMD_FINISH, 8'($urandom_range(0, 255)));
        end
      end
    end
    total_items = cmd_items.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_items.size() > 0 || cmd_ch.valid || pending_matches.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_matches.size() > 0)
      report_mismatch($sformatf("%0d finish results never delivered",
                                pending_matches.size()));
    if (mismatch_count == 0) begin
      $display("glob_wildcard_matcher test passed");
    end else begin
      $display("glob_wildcard_matcher test failed");
    end
    $finish;
  end

endmodule
